// ----- rtl/bitmap_range_store_core_defines.svh -----
// Assertion macros for the bit-map range store.
// Included by the checker; depends on signals named clk and rst in scope.
`ifndef BITMAP_RANGE_STORE_CORE_DEFINES_SVH
`define BITMAP_RANGE_STORE_CORE_DEFINES_SVH

// Checked outside reset only.
`define BRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define BRS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/brs_pkg.sv -----
// Shared types and constants for the bit-map range store.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package brs_pkg;

  localparam int INDEX_W   = 12;
  localparam int LEN_W     = 13;
  localparam int PADDR_W   = 2;
  localparam int PDATA_W   = 32;
  localparam int DIV_SHIFT = 20;

  localparam logic [LEN_W-1:0]   LEN_RESET       = 13'd4096;
  localparam logic [PADDR_W-1:0] ADDR_BITS_IN_USE = 2'd0;

  typedef enum logic [1:0] {
    REQ_WRITE_BIT   = 2'd0,
    REQ_WRITE_RANGE = 2'd1,
    REQ_READ_BIT    = 2'd2,
    REQ_CLEAR_ALL   = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_RD,
    ST_WR,
    ST_CLR,
    ST_RESP
  } brs_state_t;

  typedef struct packed {
    logic load_item;
    logic do_div;
    logic do_fix;
    logic grp_start;
    logic grp_clear;
    logic grp_inc;
    logic mem_rd;
    logic mem_wr_mod;
    logic mem_wr_zero;
    logic result_load;
  } brs_cmd_t;

  typedef struct packed {
    req_kind_t kind;
    logic      req_ok;
    logic      grp_last;
    logic      clr_last;
    logic      init_last;
    logic      out_held;
  } brs_status_t;

endpackage

`default_nettype wire

// ----- rtl/brs_ctrl.sv -----
// Controller state machine for the bit-map range store.
// Depends on brs_pkg; drives the datapath by command and reads its status.
`default_nettype none

module brs_ctrl
  import brs_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  brs_status_t status,
  output brs_cmd_t    cmd
);

  brs_state_t state;
  brs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.mem_wr_zero = 1'b1;
        if (status.init_last) begin
          state_next = ST_IDLE;
        end else begin
          cmd.grp_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.do_div = 1'b1;
        state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd.do_fix = 1'b1;
        priority if (!status.req_ok) begin
          state_next = ST_RESP;
        end else if (status.kind == REQ_CLEAR_ALL) begin
          cmd.grp_clear = 1'b1;
          state_next    = ST_CLR;
        end else begin
          cmd.grp_start = 1'b1;
          state_next    = ST_RD;
        end
      end
      ST_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_WR;
      end
      ST_WR: begin
        priority if (status.kind == REQ_READ_BIT) begin
          state_next = ST_RESP;
        end else if (status.grp_last) begin
          cmd.mem_wr_mod = 1'b1;
          state_next     = ST_RESP;
        end else begin
          cmd.mem_wr_mod = 1'b1;
          cmd.grp_inc    = 1'b1;
          state_next     = ST_RD;
        end
      end
      ST_CLR: begin
        cmd.mem_wr_zero = 1'b1;
        if (status.clr_last) begin
          state_next = ST_RESP;
        end else begin
          cmd.grp_inc = 1'b1;
        end
      end
      ST_RESP: begin
        if (!status.out_held) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/brs_datapath.sv -----
// Datapath for the bit-map range store: request registers, index split,
// group memory with read-modify-write, and the result register. Uses brs_pkg.
`default_nettype none

module brs_datapath
  import brs_pkg::*;
#(
  parameter int GROUP_WIDTH = 64,
  parameter int NUM_GROUPS  = 64
) (
  input  wire                      clk,
  input  wire                      rst,
  input  brs_cmd_t                 cmd,
  input  wire  [LEN_W-1:0]         len,
  input  req_kind_t                in_kind,
  input  wire  [INDEX_W-1:0]       in_first,
  input  wire  [INDEX_W-1:0]       in_last,
  input  wire                      in_fill,
  input  wire                      out_ready,
  output brs_status_t              status,
  output logic                     out_valid,
  output logic                     out_ok,
  output logic                     out_rbit
);

  localparam int AW     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int BW     = $clog2(GROUP_WIDTH);
  localparam int PROD_W = INDEX_W + DIV_SHIFT - 2;
  localparam int BASE_W = LEN_W + 1;
  localparam logic [PROD_W-1:0]  RECIP   = PROD_W'((1 << DIV_SHIFT) / GROUP_WIDTH);
  localparam logic [INDEX_W-1:0] GW_IDX  = INDEX_W'(GROUP_WIDTH);
  localparam logic [BW-1:0]      GW_TOP  = BW'(GROUP_WIDTH - 1);
  localparam logic [BASE_W-1:0]  GW_BASE = BASE_W'(GROUP_WIDTH);
  localparam logic [AW-1:0]      GRP_END = AW'(NUM_GROUPS - 1);

  req_kind_t                kind;
  logic [INDEX_W-1:0]       lo;
  logic [INDEX_W-1:0]       hi;
  logic                     fill;
  logic                     req_ok;
  logic [INDEX_W-1:0]       q_lo0;
  logic [INDEX_W-1:0]       q_hi0;
  logic [INDEX_W-1:0]       gs;
  logic [INDEX_W-1:0]       ge;
  logic [BW-1:0]            rlo;
  logic [BW-1:0]            rhi;
  logic [AW-1:0]            grp;
  logic [BASE_W-1:0]        base;
  logic [GROUP_WIDTH-1:0]   rdata;
  logic [GROUP_WIDTH-1:0]   mem [NUM_GROUPS];

  logic [INDEX_W-1:0]       lo_in;
  logic [INDEX_W-1:0]       hi_in;
  logic                     ok_in;
  logic [PROD_W-1:0]        prod_lo;
  logic [PROD_W-1:0]        prod_hi;
  logic [INDEX_W-1:0]       rem_lo;
  logic [INDEX_W-1:0]       rem_hi;
  logic [INDEX_W-1:0]       gs_fix;
  logic [INDEX_W-1:0]       ge_fix;
  logic [BW-1:0]            rlo_fix;
  logic [BW-1:0]            rhi_fix;
  logic [GROUP_WIDTH-1:0]   mask_s;
  logic [GROUP_WIDTH-1:0]   mask_e;
  logic [GROUP_WIDTH-1:0]   mask;
  logic [GROUP_WIDTH-1:0]   wdata;
  logic                     mem_wr;

  // Request capture: order the range ends and check them against the length.
  always_comb begin
    if (in_kind == REQ_WRITE_RANGE) begin
      lo_in = (in_first < in_last) ? in_first : in_last;
      hi_in = (in_first < in_last) ? in_last : in_first;
    end else begin
      lo_in = in_first;
      hi_in = in_first;
    end
    if (in_kind == REQ_CLEAR_ALL) begin
      ok_in = (len != '0);
    end else begin
      ok_in = ({1'b0, hi_in} < len);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind   <= in_kind;
      lo     <= lo_in;
      hi     <= hi_in;
      fill   <= in_fill;
      req_ok <= ok_in;
    end
  end

  // Group and bit position by reciprocal multiply, then one correction step.
  assign prod_lo = PROD_W'(lo) * RECIP;
  assign prod_hi = PROD_W'(hi) * RECIP;

  always_ff @(posedge clk) begin
    if (cmd.do_div) begin
      q_lo0 <= INDEX_W'(prod_lo >> DIV_SHIFT);
      q_hi0 <= INDEX_W'(prod_hi >> DIV_SHIFT);
    end
  end

  assign rem_lo = lo - INDEX_W'(q_lo0 * GW_IDX);
  assign rem_hi = hi - INDEX_W'(q_hi0 * GW_IDX);

  always_comb begin
    if (rem_lo >= GW_IDX) begin
      gs_fix  = q_lo0 + 1'b1;
      rlo_fix = BW'(rem_lo - GW_IDX);
    end else begin
      gs_fix  = q_lo0;
      rlo_fix = BW'(rem_lo);
    end
    if (rem_hi >= GW_IDX) begin
      ge_fix  = q_hi0 + 1'b1;
      rhi_fix = BW'(rem_hi - GW_IDX);
    end else begin
      ge_fix  = q_hi0;
      rhi_fix = BW'(rem_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_fix) begin
      gs  <= gs_fix;
      ge  <= ge_fix;
      rlo <= rlo_fix;
      rhi <= rhi_fix;
    end
  end

  // Group walk counter and the running bit offset used by clear-all.
  always_ff @(posedge clk) begin
    if (rst) begin
      grp  <= '0;
      base <= '0;
    end else begin
      priority if (cmd.grp_clear) begin
        grp  <= '0;
        base <= '0;
      end else if (cmd.grp_start) begin
        grp <= gs_fix[AW-1:0];
      end else if (cmd.grp_inc) begin
        grp  <= grp + 1'b1;
        base <= base + GW_BASE;
      end
    end
  end

  // Edge masks apply only on the first and last groups of a range.
  always_comb begin
    mask_s = (grp == gs[AW-1:0]) ? ({GROUP_WIDTH{1'b1}} << rlo) : {GROUP_WIDTH{1'b1}};
    mask_e = (grp == ge[AW-1:0]) ? ({GROUP_WIDTH{1'b1}} >> (GW_TOP - rhi))
                                 : {GROUP_WIDTH{1'b1}};
    mask   = mask_s & mask_e;
    if (cmd.mem_wr_zero) begin
      wdata = '0;
    end else if (fill) begin
      wdata = rdata | mask;
    end else begin
      wdata = rdata & ~mask;
    end
    mem_wr = cmd.mem_wr_zero | cmd.mem_wr_mod;
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[grp] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[grp];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_ok   <= req_ok;
      out_rbit <= (kind == REQ_READ_BIT) & req_ok & rdata[rlo];
    end
  end

  always_comb begin
    status.kind      = kind;
    status.req_ok    = req_ok;
    status.grp_last  = (grp == ge[AW-1:0]);
    status.clr_last  = ((base + GW_BASE) >= {1'b0, len});
    status.init_last = (grp == GRP_END);
    status.out_held  = out_valid & ~out_ready;
  end

endmodule

`default_nettype wire

// ----- rtl/bitmap_range_store_core.sv -----
// Each request passes the divide and fix steps; a refused one then goes to its result. A
// bit read reads one group; a bit or range write reads and writes back each group spanned
// on the single memory port; clear-all zeroes ceil(length/width) groups. No request is
// taken until the prior result is loaded, which waits while an older one is held. Reset is
// synchronous; afterwards a sweep over all NUM_GROUPS groups zeroes the store and no
// request is taken until it ends. Register writes are accepted throughout.
`default_nettype none

module bitmap_range_store_core
  import brs_pkg::*;
#(
  parameter int GROUP_WIDTH = 64,
  parameter int NUM_GROUPS  = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  wire  [31:0]         s_tdata,   // first_index[11:0], last_index[23:12], fill_value[24]
  input  wire  [1:0]          s_tuser,   // req_type[1:0]
  output logic                m_tvalid,
  input  wire                 m_tready,
  output logic [7:0]          m_tdata,   // ok[0], read_bit[1]
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [PADDR_W-1:0]  paddr,
  input  wire  [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int CAP = GROUP_WIDTH * NUM_GROUPS;

  logic [LEN_W-1:0] bits_in_use;
  logic [LEN_W-1:0] eff_len;
  brs_cmd_t         cmd;
  brs_status_t      status;
  logic             out_ok;
  logic             out_rbit;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= LEN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_BITS_IN_USE)) begin
      bits_in_use <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata  = (paddr == ADDR_BITS_IN_USE) ? PDATA_W'(bits_in_use) : '0;
  assign eff_len = (32'(bits_in_use) < CAP) ? bits_in_use : LEN_W'(CAP);

  brs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  brs_datapath #(
    .GROUP_WIDTH (GROUP_WIDTH),
    .NUM_GROUPS  (NUM_GROUPS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .len       (eff_len),
    .in_kind   (req_kind_t'(s_tuser)),
    .in_first  (s_tdata[11:0]),
    .in_last   (s_tdata[23:12]),
    .in_fill   (s_tdata[24]),
    .out_ready (m_tready),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ok    (out_ok),
    .out_rbit  (out_rbit)
  );

  assign m_tdata = {6'b0, out_rbit, out_ok};

endmodule

`default_nettype wire

// ----- rtl/brs_checker.sv -----
// Port-level checks for the bit-map range store, bound to the top level.
// Depends on bitmap_range_store_core_defines.svh for the assertion macros.
`default_nettype none

`include "bitmap_range_store_core_defines.svh"

module brs_checker (
  input wire       clk,
  input wire       rst,
  input wire       s_tvalid,
  input wire       s_tready,
  input wire       m_tvalid,
  input wire       m_tready,
  input wire [7:0] m_tdata
);

  `BRS_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_tvalid && !s_tready, "outputs active after reset")
  `BRS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped")
  `BRS_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "second request taken early")
  `BRS_ASSERT(a_result_busy, $rose(m_tvalid) |-> !$past(s_tready), "result without a request")

endmodule

bind bitmap_range_store_core brs_checker u_brs_checker (.*);

`default_nettype wire
